FILE: sv/rgmc_pkg.sv
// Shared types and constants for the roll-guarded motor command gate.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rgmc_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_DUTY  = 2'd1,
        ACT_SPEED = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_CUTOFF_LEVEL  = 3'd0,
        CFG_RECOVER_LEVEL = 3'd1,
        CFG_RECOVER_DELAY = 3'd2,
        CFG_STOP_LOCK     = 3'd3,
        CFG_DUTY_LIMIT    = 3'd4,
        CFG_SPEED_LIMIT   = 3'd5
    } cfg_index_t;

    localparam logic [14:0] CUTOFF_LEVEL_RST  = 15'd2100;
    localparam logic [14:0] RECOVER_LEVEL_RST = 15'd1000;
    localparam logic [15:0] RECOVER_DELAY_RST = 16'd500;
    localparam logic [15:0] STOP_LOCK_RST     = 16'd4000;
    localparam logic [14:0] DUTY_LIMIT_RST    = 15'd5000;
    localparam logic [14:0] SPEED_LIMIT_RST   = 15'd3000;

    typedef struct packed {
        logic [14:0] cutoff_level;
        logic [14:0] recover_level;
        logic [15:0] recover_delay_ms;
        logic [15:0] stop_lock_ms;
        logic [14:0] duty_limit;
        logic [14:0] speed_limit;
    } cfg_t;

    // Classified item as it travels from the front end to the back end.
    typedef struct packed {
        action_t            action;
        logic signed [15:0] value;      // clamped duty or speed
        logic               roll_low;   // |roll| <= recover_level
        logic               roll_high;  // |roll| >= cutoff_level
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic               speed_valid;
        logic signed [15:0] speed_out;
        logic               duty_valid;
        logic signed [15:0] duty_out;
        logic               servo_hold;
        logic               pid_reset;
        logic               guard_active;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/rgmc_cfg_regs.sv
// Configuration register file for the roll-guarded motor command gate.
// Depends on rgmc_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps
`default_nettype none

module rgmc_cfg_regs (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         wr_en,
    input  wire logic [2:0]   wr_index,
    input  wire logic [15:0]  wr_data,
    output rgmc_pkg::cfg_t    cfg
);

    rgmc_pkg::cfg_t cfg_reg;
    rgmc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (rgmc_pkg::cfg_index_t'(wr_index))
                rgmc_pkg::CFG_CUTOFF_LEVEL:  cfg_next.cutoff_level     = wr_data[14:0];
                rgmc_pkg::CFG_RECOVER_LEVEL: cfg_next.recover_level    = wr_data[14:0];
                rgmc_pkg::CFG_RECOVER_DELAY: cfg_next.recover_delay_ms = wr_data;
                rgmc_pkg::CFG_STOP_LOCK:     cfg_next.stop_lock_ms     = wr_data;
                rgmc_pkg::CFG_DUTY_LIMIT:    cfg_next.duty_limit       = wr_data[14:0];
                rgmc_pkg::CFG_SPEED_LIMIT:   cfg_next.speed_limit      = wr_data[14:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cutoff_level     <= rgmc_pkg::CUTOFF_LEVEL_RST;
            cfg_reg.recover_level    <= rgmc_pkg::RECOVER_LEVEL_RST;
            cfg_reg.recover_delay_ms <= rgmc_pkg::RECOVER_DELAY_RST;
            cfg_reg.stop_lock_ms     <= rgmc_pkg::STOP_LOCK_RST;
            cfg_reg.duty_limit       <= rgmc_pkg::DUTY_LIMIT_RST;
            cfg_reg.speed_limit      <= rgmc_pkg::SPEED_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/rgmc_front.sv
// Front end: classifies an incoming item (roll magnitude vs. levels, clamp).
// Depends on rgmc_pkg (action_t, cfg_t, item_t).
`timescale 1ns / 1ps
`default_nettype none

module rgmc_front (
    input  wire logic [1:0]         action,
    input  wire logic signed [15:0] command_value,
    input  wire logic signed [15:0] roll_angle,
    input  wire logic [31:0]        now_ms,
    input  rgmc_pkg::cfg_t          cfg,
    output rgmc_pkg::item_t         item
);

    logic [15:0]        roll_mag;
    logic [14:0]        limit;
    logic signed [16:0] value_ext;
    logic signed [16:0] limit_pos;
    logic signed [16:0] limit_neg;
    logic signed [15:0] clamped;

    // -32768 magnitude wraps to 16'h8000, which is 32768 read unsigned
    assign roll_mag = roll_angle[15] ? 16'(-roll_angle) : roll_angle;

    always_comb begin
        limit = (rgmc_pkg::action_t'(action) == rgmc_pkg::ACT_DUTY) ?
                cfg.duty_limit : cfg.speed_limit;
        value_ext = {command_value[15], command_value};
        limit_pos = {2'b00, limit};
        limit_neg = -limit_pos;
        if (value_ext > limit_pos) begin
            clamped = limit_pos[15:0];
        end else if (value_ext < limit_neg) begin
            clamped = limit_neg[15:0];
        end else begin
            clamped = command_value;
        end
    end

    always_comb begin
        item.action    = rgmc_pkg::action_t'(action);
        item.value     = clamped;
        item.roll_low  = roll_mag <= {1'b0, cfg.recover_level};
        item.roll_high = roll_mag >= {1'b0, cfg.cutoff_level};
        item.now_ms    = now_ms;
    end

endmodule

`default_nettype wire

FILE: sv/rgmc_queue.sv
// Short FIFO between the front and back ends of the command gate.
// Depends on rgmc_pkg (item_t).
`timescale 1ns / 1ps
`default_nettype none

module rgmc_queue #(
    parameter int Depth = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  rgmc_pkg::item_t  push_item,
    output logic             full,
    input  wire logic        pop,
    output logic             head_valid,
    output rgmc_pkg::item_t  head_item
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    rgmc_pkg::item_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = count_reg == CntW'(Depth);
    assign head_valid = count_reg != '0;
    assign head_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rgmc_back.sv
// Back end: guard state machine, command gating and the result register.
// Depends on rgmc_pkg (action_t, cfg_t, item_t, result_t).
`timescale 1ns / 1ps
`default_nettype none

module rgmc_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  rgmc_pkg::cfg_t   cfg,
    input  wire logic        head_valid,
    input  rgmc_pkg::item_t  head_item,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rgmc_pkg::result_t result
);

    logic               guarded_reg,         guarded_next;
    logic               recover_pending_reg, recover_pending_next;
    logic [31:0]        recover_start_reg,   recover_start_next;
    logic               last_was_speed_reg,  last_was_speed_next;
    logic signed [15:0] last_speed_reg,      last_speed_next;
    logic signed [15:0] resume_speed_reg,    resume_speed_next;
    logic               resume_ready_reg,    resume_ready_next;
    logic               stop_locked_reg,     stop_locked_next;
    logic [31:0]        lock_start_reg,      lock_start_next;
    logic               out_valid_reg,       out_valid_next;
    rgmc_pkg::result_t  result_reg,          result_next;

    // roll evaluation outcome for the head item
    logic        eval_guarded;
    logic        eval_pending;
    logic [31:0] eval_start;
    logic [31:0] recover_elapsed;
    logic [31:0] lock_elapsed;
    logic        lock_running;
    logic        resume_ok;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    assign recover_elapsed = head_item.now_ms - recover_start_reg;
    assign lock_elapsed    = head_item.now_ms - lock_start_reg;
    assign lock_running    = stop_locked_reg && (lock_elapsed < {16'd0, cfg.stop_lock_ms});
    assign resume_ok       = last_was_speed_reg && resume_ready_reg;

    always_comb begin
        eval_guarded = guarded_reg;
        eval_pending = recover_pending_reg;
        eval_start   = recover_start_reg;
        if (guarded_reg) begin
            if (head_item.roll_low) begin
                if (!recover_pending_reg) begin
                    eval_pending = 1'b1;
                    eval_start   = head_item.now_ms;
                end else if (recover_elapsed >= {16'd0, cfg.recover_delay_ms}) begin
                    eval_guarded = 1'b0;
                    eval_pending = 1'b0;
                end
            end else begin
                eval_pending = 1'b0;
            end
        end else if (head_item.roll_high) begin
            eval_guarded = 1'b1;
            eval_pending = 1'b0;
        end
    end

    always_comb begin
        guarded_next         = guarded_reg;
        recover_pending_next = recover_pending_reg;
        recover_start_next   = recover_start_reg;
        last_was_speed_next  = last_was_speed_reg;
        last_speed_next      = last_speed_reg;
        resume_speed_next    = resume_speed_reg;
        resume_ready_next    = resume_ready_reg;
        stop_locked_next     = stop_locked_reg;
        lock_start_next      = lock_start_reg;
        result_next          = '0;

        case (head_item.action)
            rgmc_pkg::ACT_TICK: begin
                if (lock_running) begin
                    guarded_next           = 1'b1;
                    recover_pending_next   = 1'b0;
                    result_next.servo_hold = 1'b1;
                end else begin
                    stop_locked_next       = 1'b0;
                    guarded_next           = eval_guarded;
                    recover_pending_next   = eval_pending;
                    recover_start_next     = eval_start;
                    result_next.servo_hold = eval_guarded;
                    if (!guarded_reg && eval_guarded) begin
                        // entering protection: zero the last kind of command
                        if (resume_ok) begin
                            resume_speed_next = last_speed_reg;
                        end
                        result_next.speed_valid = last_was_speed_reg;
                        result_next.duty_valid  = !last_was_speed_reg;
                    end else if (guarded_reg && !eval_guarded) begin
                        result_next.pid_reset = 1'b1;
                        if (resume_ok) begin
                            result_next.speed_valid = 1'b1;
                            result_next.speed_out   = resume_speed_reg;
                        end
                    end
                end
            end
            rgmc_pkg::ACT_DUTY: begin
                last_was_speed_next    = 1'b0;
                resume_ready_next      = 1'b0;
                guarded_next           = eval_guarded;
                recover_pending_next   = eval_pending;
                recover_start_next     = eval_start;
                result_next.duty_valid = 1'b1;
                result_next.duty_out   = eval_guarded ? 16'sd0 : head_item.value;
            end
            rgmc_pkg::ACT_SPEED: begin
                last_was_speed_next     = 1'b1;
                last_speed_next         = head_item.value;
                resume_speed_next       = head_item.value;
                resume_ready_next       = head_item.value != 16'sd0;
                guarded_next            = eval_guarded;
                recover_pending_next    = eval_pending;
                recover_start_next      = eval_start;
                result_next.speed_valid = 1'b1;
                result_next.speed_out   = eval_guarded ? 16'sd0 : head_item.value;
            end
            rgmc_pkg::ACT_STOP: begin
                if (last_was_speed_reg && last_speed_reg != 16'sd0) begin
                    resume_speed_next = last_speed_reg;
                    resume_ready_next = 1'b1;
                end
                guarded_next            = 1'b1;
                recover_pending_next    = 1'b0;
                stop_locked_next        = 1'b1;
                lock_start_next         = head_item.now_ms;
                result_next.servo_hold  = 1'b1;
                result_next.speed_valid = 1'b1;
                result_next.duty_valid  = 1'b1;
            end
            default: ;
        endcase
        result_next.guard_active = guarded_next;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guarded_reg         <= 1'b1;
            recover_pending_reg <= 1'b0;
            recover_start_reg   <= '0;
            last_was_speed_reg  <= 1'b0;
            last_speed_reg      <= '0;
            resume_speed_reg    <= '0;
            resume_ready_reg    <= 1'b0;
            stop_locked_reg     <= 1'b0;
            lock_start_reg      <= '0;
            out_valid_reg       <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                guarded_reg         <= guarded_next;
                recover_pending_reg <= recover_pending_next;
                recover_start_reg   <= recover_start_next;
                last_was_speed_reg  <= last_was_speed_next;
                last_speed_reg      <= last_speed_next;
                resume_speed_reg    <= resume_speed_next;
                resume_ready_reg    <= resume_ready_next;
                stop_locked_reg     <= stop_locked_next;
                lock_start_reg      <= lock_start_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef SYNTHESIS
    // a controller reset is only requested when protection has just ended
    a_pid_reset_unguarded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.pid_reset |-> !result_reg.guard_active)
        else $error("pid_reset issued while still guarded");

    // a stop always leaves the block guarded and locked
    a_stop_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && head_item.action == rgmc_pkg::ACT_STOP |=> guarded_reg && stop_locked_reg)
        else $error("stop did not lock the guard");

    // recovery timing only runs while guarded
    a_pending_needs_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        !guarded_reg |-> !recover_pending_reg)
        else $error("recovery pending while unguarded");

    // both commands in one item only happen on a stop, and both are zero
    a_dual_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.speed_valid && result_reg.duty_valid
        |-> result_reg.speed_out == 16'sd0 && result_reg.duty_out == 16'sd0
            && result_reg.guard_active)
        else $error("dual command item is not a zeroing stop");
`endif

endmodule

`default_nettype wire

FILE: sv/roll_guarded_motor_command_gate_top.sv
// Roll-guarded motor command gate: an accepted item goes to a queue slot, then to the
// result register that drives m_valid; throughput one item per cycle while m_ready
// is held high, set by the guard state update in the back end. s_ready drops only
// when the queue is full. aresetn is synchronous, active low: the block comes up guarded,
// queue empty, no result pending; all registers but the queue memory and result are reset.
// Depends on rgmc_pkg and rgmc_cfg_regs, rgmc_front, rgmc_queue, rgmc_back.
`timescale 1ns / 1ps
`default_nettype none

module roll_guarded_motor_command_gate_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // input item channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic signed [15:0] s_command_value,
    input  wire logic signed [15:0] s_roll_angle,
    input  wire logic [31:0]        s_now_ms,

    // result item channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_speed_valid,
    output logic signed [15:0]      m_speed_out,
    output logic                    m_duty_valid,
    output logic signed [15:0]      m_duty_out,
    output logic                    m_servo_hold,
    output logic                    m_pid_reset,
    output logic                    m_guard_active,

    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    rgmc_pkg::cfg_t    cfg;
    rgmc_pkg::item_t   front_item;
    rgmc_pkg::item_t   head_item;
    rgmc_pkg::result_t result;
    logic              queue_full;
    logic              head_valid;
    logic              pop;
    logic              push;

    // Register writes are always taken; software only writes while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    rgmc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Front end: roll magnitude against both levels, clamp of the command.
    rgmc_front u_front (
        .action        (s_action),
        .command_value (s_command_value),
        .roll_angle    (s_roll_angle),
        .now_ms        (s_now_ms),
        .cfg           (cfg),
        .item          (front_item)
    );

    // An item is accepted whenever the queue has room.
    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    rgmc_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (front_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: hysteresis, stop lock, edge commands; pops when the result
    // register is free or being drained this cycle.
    rgmc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .result     (result)
    );

    assign m_speed_valid  = result.speed_valid;
    assign m_speed_out    = result.speed_out;
    assign m_duty_valid   = result.duty_valid;
    assign m_duty_out     = result.duty_out;
    assign m_servo_hold   = result.servo_hold;
    assign m_pid_reset    = result.pid_reset;
    assign m_guard_active = result.guard_active;

endmodule

`default_nettype wire
